[hw/rtl/mvm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix-vector multiply package
// Shared types and constants for the matrix-vector multiply block.
// ----------------------------------------------------------------------------
package mvm_pkg;

    // Operation codes carried on the op field of an input transfer.
    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_VECTOR = 1'b1;

    // Configuration register indexes.
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Field widths fixed by the interface.
    localparam int VALUE_W = 16;
    localparam int PROD_W  = 32;
    localparam int SUM_W   = 40;
    localparam int IDX_W   = 4;
    localparam int COUNT_W = 5;

    // Tag that travels with each operand pair through the shared MAC.
    typedef struct packed {
        logic             first;
        logic             last_col;
        logic [IDX_W-1:0] row;
        logic             last_row;
    } mvm_tag_t;

endpackage

[hw/rtl/mvm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/mvm_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Multiplies one weight by one vector element per cycle and accumulates a row.
// ----------------------------------------------------------------------------
module mvm_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  mvm_pkg::mvm_tag_t                    in_tag,
    input  logic signed [mvm_pkg::VALUE_W-1:0]   weight,
    input  logic signed [mvm_pkg::VALUE_W-1:0]   element,
    output logic                                 pipe_busy,
    output logic                                 done,
    output logic [mvm_pkg::IDX_W-1:0]            out_row,
    output logic signed [mvm_pkg::SUM_W-1:0]     product_sum,
    output logic                                 last
);

    logic                                   p_valid_reg;
    mvm_pkg::mvm_tag_t                      p_tag_reg;
    logic signed [mvm_pkg::PROD_W-1:0]      prod_reg;
    logic signed [mvm_pkg::SUM_W-1:0]       prod_ext;
    logic signed [mvm_pkg::SUM_W-1:0]       acc_reg;
    logic signed [mvm_pkg::SUM_W-1:0]       acc_next;
    logic                                   done_reg;
    logic [mvm_pkg::IDX_W-1:0]              row_reg;
    logic                                   last_reg;

    // Multiply stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_valid;
        end
    end

    // Multiply stage payload: exact Q16.16 product.
    always_ff @(posedge clk)
    begin
        prod_reg  <= weight * element;
        p_tag_reg <= in_tag;
    end

    // Accumulate: the first column of a row restarts the sum.
    assign prod_ext = {{(mvm_pkg::SUM_W - mvm_pkg::PROD_W){prod_reg[mvm_pkg::PROD_W-1]}},
                       prod_reg};

    always_comb
    begin
        if (p_tag_reg.first)
        begin
            acc_next = prod_ext;
        end
        else
        begin
            acc_next = acc_reg + prod_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_valid_reg)
        begin
            acc_reg  <= acc_next;
            row_reg  <= p_tag_reg.row;
            last_reg <= p_tag_reg.last_row;
        end
    end

    // The result strobe follows the last column of each row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= p_valid_reg & p_tag_reg.last_col;
        end
    end

    assign pipe_busy   = p_valid_reg;
    assign done        = done_reg;
    assign out_row     = row_reg;
    assign product_sum = acc_reg;
    assign last        = last_reg;

endmodule

[hw/rtl/matrix_vector_multiply_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix-vector multiply top level
// Stores a Q8.8 matrix and vector and streams one Q24.16 dot product per row.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                    Payload
//  input     in         start high while busy low    op, row_index, column_index, value
//  result    out        done strobe, one cycle        out_row, product_sum, last
//  config    in/out     APB write/read, pready high  row and column counts
//
//  A weight write, or a vector write that does not complete the vector, is
//  taken while busy stays low. The vector write to the last column in use keeps
//  busy high until every row is done: the single shared multiply-accumulate unit
//  does one product per cycle, behind the registered RAM read and multiply
//  stages. Results cannot be stalled by the receiver. After reset the block
//  is ready at once; the matrix and vector stores hold nothing until written.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_top #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input transfers
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  op,
    input  logic [mvm_pkg::IDX_W-1:0]             row_index,
    input  logic [mvm_pkg::IDX_W-1:0]             column_index,
    input  logic signed [mvm_pkg::VALUE_W-1:0]    value,
    // Result transfers
    output logic                                  done,
    output logic [mvm_pkg::IDX_W-1:0]             out_row,
    output logic signed [mvm_pkg::SUM_W-1:0]      product_sum,
    output logic                                  last,
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int W_DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int WAW       = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int VAW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_LIMIT = (MAX_ROWS < 16) ? MAX_ROWS : 16;
    localparam int COL_LIMIT = (MAX_COLS < 16) ? MAX_COLS : 16;
    localparam int LIM_W     = 7;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic [mvm_pkg::COUNT_W-1:0] rows_cfg_reg;
    logic [mvm_pkg::COUNT_W-1:0] cols_cfg_reg;
    logic [mvm_pkg::COUNT_W-1:0] rows_use;
    logic [mvm_pkg::COUNT_W-1:0] cols_use;
    logic                        cfg_write;

    logic                        state_reg;
    logic                        state_next;
    logic [mvm_pkg::IDX_W-1:0]   row_reg;
    logic [mvm_pkg::IDX_W-1:0]   row_next;
    logic [mvm_pkg::IDX_W-1:0]   col_reg;
    logic [mvm_pkg::IDX_W-1:0]   col_next;

    logic                        accept;
    logic                        row_in_range;
    logic                        col_in_range;
    logic                        weight_wr;
    logic                        vector_wr;
    logic                        go;
    logic                        col_end;
    logic                        row_end;

    logic [WAW-1:0]              w_wr_addr;
    logic [WAW-1:0]              w_rd_addr;
    logic [VAW-1:0]              v_wr_addr;
    logic [VAW-1:0]              v_rd_addr;
    logic [mvm_pkg::VALUE_W-1:0] w_rd_data;
    logic [mvm_pkg::VALUE_W-1:0] v_rd_data;

    mvm_pkg::mvm_tag_t           issue_tag;
    mvm_pkg::mvm_tag_t           rd_tag_reg;
    logic                        rd_valid_reg;
    logic                        mac_busy;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= 5'd16;
            cols_cfg_reg <= 5'd16;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                mvm_pkg::REG_ROWS: rows_cfg_reg <= pwdata[mvm_pkg::COUNT_W-1:0];
                mvm_pkg::REG_COLS: cols_cfg_reg <= pwdata[mvm_pkg::COUNT_W-1:0];
                default:           rows_cfg_reg <= rows_cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            mvm_pkg::REG_ROWS: prdata = {27'd0, rows_cfg_reg};
            mvm_pkg::REG_COLS: prdata = {27'd0, cols_cfg_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // Counts in use: zero reads as one, and both are capped at the store size.
    always_comb
    begin
        if (rows_cfg_reg == '0)
        begin
            rows_use = 5'd1;
        end
        else if (rows_cfg_reg > mvm_pkg::COUNT_W'(ROW_LIMIT))
        begin
            rows_use = mvm_pkg::COUNT_W'(ROW_LIMIT);
        end
        else
        begin
            rows_use = rows_cfg_reg;
        end

        if (cols_cfg_reg == '0)
        begin
            cols_use = 5'd1;
        end
        else if (cols_cfg_reg > mvm_pkg::COUNT_W'(COL_LIMIT))
        begin
            cols_use = mvm_pkg::COUNT_W'(COL_LIMIT);
        end
        else
        begin
            cols_use = cols_cfg_reg;
        end
    end

    // Input decode: out-of-store writes are dropped.
    assign accept       = start & ~busy;
    assign row_in_range = LIM_W'(row_index) < LIM_W'(MAX_ROWS);
    assign col_in_range = LIM_W'(column_index) < LIM_W'(MAX_COLS);
    assign weight_wr    = accept & (op == mvm_pkg::OP_WEIGHT) & row_in_range & col_in_range;
    assign vector_wr    = accept & (op == mvm_pkg::OP_VECTOR) & col_in_range;
    assign go           = vector_wr & ({1'b0, column_index} == (cols_use - 5'd1));

    assign w_wr_addr = WAW'(row_index) * WAW'(MAX_COLS) + WAW'(column_index);
    assign v_wr_addr = VAW'(column_index);
    assign w_rd_addr = WAW'(row_reg) * WAW'(MAX_COLS) + WAW'(col_reg);
    assign v_rd_addr = VAW'(col_reg);

    // Sequencer: walks columns within rows, one operand pair per cycle.
    assign col_end = {1'b0, col_reg} == (cols_use - 5'd1);
    assign row_end = {1'b0, row_reg} == (rows_use - 5'd1);

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    state_next = ST_RUN;
                    row_next   = '0;
                    col_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (col_end)
                begin
                    col_next = '0;
                    row_next = row_reg + 4'd1;
                    if (row_end)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    col_next = col_reg + 4'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            rd_valid_reg <= (state_reg == ST_RUN);
        end
    end

    // Tag travels alongside the registered RAM read.
    always_comb
    begin
        issue_tag.first    = (col_reg == '0);
        issue_tag.last_col = col_end;
        issue_tag.row      = row_reg;
        issue_tag.last_row = row_end;
    end

    always_ff @(posedge clk)
    begin
        rd_tag_reg <= issue_tag;
    end

    assign busy = (state_reg == ST_RUN) | rd_valid_reg | mac_busy;

    // Weight and vector stores.
    mvm_ram #(
        .WIDTH (mvm_pkg::VALUE_W),
        .DEPTH (W_DEPTH),
        .AW    (WAW)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (weight_wr),
        .wr_addr (w_wr_addr),
        .wr_data (value),
        .rd_addr (w_rd_addr),
        .rd_data (w_rd_data)
    );

    mvm_ram #(
        .WIDTH (mvm_pkg::VALUE_W),
        .DEPTH (MAX_COLS),
        .AW    (VAW)
    ) u_vector_ram (
        .clk     (clk),
        .wr_en   (vector_wr),
        .wr_addr (v_wr_addr),
        .wr_data (value),
        .rd_addr (v_rd_addr),
        .rd_data (v_rd_data)
    );

    // Shared multiply-accumulate unit.
    mvm_mac u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (rd_valid_reg),
        .in_tag      (rd_tag_reg),
        .weight      ($signed(w_rd_data)),
        .element     ($signed(v_rd_data)),
        .pipe_busy   (mac_busy),
        .done        (done),
        .out_row     (out_row),
        .product_sum (product_sum),
        .last        (last)
    );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix-vector multiply testbench
// Sends weight and vector-element transfers to matrix_vector_multiply_top,
// works out every row dot product alongside the block and checks each result
// transfer field by field. Row and column counts are changed over the APB
// port between products, through small, zero, full-size and over-range values.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF      = 6;
    localparam int STORE_DIM     = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_TARGET = 220;
    localparam int TOTAL_TARGET  = 470;

    typedef struct {
        logic                               op;
        logic [mvm_pkg::IDX_W-1:0]          row;
        logic [mvm_pkg::IDX_W-1:0]          col;
        logic signed [mvm_pkg::VALUE_W-1:0] val;
    } mv_item_t;

    typedef struct {
        logic [mvm_pkg::IDX_W-1:0]        row;
        logic signed [mvm_pkg::SUM_W-1:0] sum;
        logic                             last;
    } dot_result_t;

    logic                               clk          = 1'b0;
    logic                               rst_n        = 1'b0;
    logic                               start        = 1'b0;
    logic                               busy;
    logic                               op           = mvm_pkg::OP_WEIGHT;
    logic [mvm_pkg::IDX_W-1:0]          row_index    = '0;
    logic [mvm_pkg::IDX_W-1:0]          column_index = '0;
    logic signed [mvm_pkg::VALUE_W-1:0] value        = '0;
    logic                               done;
    logic [mvm_pkg::IDX_W-1:0]          out_row;
    logic signed [mvm_pkg::SUM_W-1:0]   product_sum;
    logic                               last;
    logic                               psel         = 1'b0;
    logic                               penable      = 1'b0;
    logic                               pwrite       = 1'b0;
    logic [2:0]                         paddr        = '0;
    logic [31:0]                        pwdata       = '0;
    logic [31:0]                        prdata;
    logic                               pready;

    // Testbench copy of the stores and the count registers.
    logic signed [mvm_pkg::VALUE_W-1:0] weights [STORE_DIM][STORE_DIM];
    logic signed [mvm_pkg::VALUE_W-1:0] vector_store [STORE_DIM];
    bit                                 weight_written [STORE_DIM][STORE_DIM];
    bit                                 vector_written [STORE_DIM];
    logic [mvm_pkg::COUNT_W-1:0]        row_setting = 5'd16;
    logic [mvm_pkg::COUNT_W-1:0]        col_setting = 5'd16;

    dot_result_t expected_dots[$];

    bit idle_on         = 1'b1;
    int error_count     = 0;
    int items_sent      = 0;
    int weight_items    = 0;
    int products        = 0;
    int dots_checked    = 0;
    int configs_applied = 0;
    int stall_cycles    = 0;

    matrix_vector_multiply_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .row_index    (row_index),
        .column_index (column_index),
        .value        (value),
        .done         (done),
        .out_row      (out_row),
        .product_sum  (product_sum),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #(CLK_HALF) clk = ~clk;

    // A count of zero behaves as one, and anything above the store size as the
    // store size.
    function automatic int clamp_count(logic [mvm_pkg::COUNT_W-1:0] setting);
        if (setting == '0)
            return 1;
        if (setting > STORE_DIM)
            return STORE_DIM;
        return int'(setting);
    endfunction

    function automatic mv_item_t make_item(logic kind, int row, int col,
                                           logic signed [mvm_pkg::VALUE_W-1:0] val);
        mv_item_t it;
        it.op  = kind;
        it.row = mvm_pkg::IDX_W'(row);
        it.col = mvm_pkg::IDX_W'(col);
        it.val = val;
        return it;
    endfunction

    // Values lean towards the Q8.8 extremes and zero.
    function automatic logic signed [mvm_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            default: return mvm_pkg::VALUE_W'($urandom());
        endcase
    endfunction

    function automatic logic [mvm_pkg::COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return mvm_pkg::COUNT_W'($urandom_range(17, 31));
            2:       return 5'd16;
            default: return mvm_pkg::COUNT_W'($urandom_range(1, 4));
        endcase
    endfunction

    // A stray write anywhere in the stores that never starts a product.
    function automatic mv_item_t make_noise(int cols_use);
        mv_item_t it;
        it = make_item($urandom_range(0, 1) ? mvm_pkg::OP_VECTOR : mvm_pkg::OP_WEIGHT,
                       $urandom_range(0, 15), $urandom_range(0, 15), pick_value());
        // An element at the last column in use would start a product.
        if (it.op == mvm_pkg::OP_VECTOR && int'(it.col) == cols_use - 1)
            it.op = mvm_pkg::OP_WEIGHT;
        return it;
    endfunction

    // Updates the stores for one accepted transfer and, when the vector is
    // complete, queues one dot product per row in use.
    task automatic predict_dot_products(mv_item_t it);
        int          rows_use;
        int          cols_use;
        longint      acc;
        dot_result_t res;
        rows_use = clamp_count(row_setting);
        cols_use = clamp_count(col_setting);
        items_sent++;
        if (it.op == mvm_pkg::OP_WEIGHT) begin
            weights[it.row][it.col] = it.val;
            weight_written[it.row][it.col] = 1'b1;
            weight_items++;
        end
        else begin
            vector_store[it.col] = it.val;
            vector_written[it.col] = 1'b1;
            if (int'(it.col) == cols_use - 1) begin
                products++;
                for (int r = 0; r < rows_use; r++) begin
                    acc = 0;
                    for (int c = 0; c < cols_use; c++)
                        acc += longint'(weights[r][c]) * longint'(vector_store[c]);
                    res.row  = mvm_pkg::IDX_W'(r);
                    res.sum  = mvm_pkg::SUM_W'(acc);
                    res.last = (r == rows_use - 1);
                    expected_dots.push_back(res);
                end
            end
        end
    endtask

    // Offers one input transfer, waits for it to be taken and sometimes
    // leaves a gap afterwards.
    task automatic send_item(mv_item_t it);
        op           <= it.op;
        row_index    <= it.row;
        column_index <= it.col;
        value        <= it.val;
        start        <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_dot_products(it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Holds the sender off until every queued result has been seen.
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_dots.size() != 0);
    endtask

    task automatic apb_write(logic reg_idx, logic [mvm_pkg::COUNT_W-1:0] val);
        logic [31:0] data;
        data = $urandom();
        data[mvm_pkg::COUNT_W-1:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (reg_idx == mvm_pkg::REG_ROWS)
            row_setting = val;
        else
            col_setting = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_check(logic reg_idx);
        logic [mvm_pkg::COUNT_W-1:0] want;
        want = (reg_idx == mvm_pkg::REG_ROWS) ? row_setting : col_setting;
        psel    <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata[mvm_pkg::COUNT_W-1:0] !== want) begin
            error_count++;
            $display("%0t: register %0d read back: expected %0d, got %0d",
                     $time, reg_idx, want, prdata[mvm_pkg::COUNT_W-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // New counts are written only once the block has gone quiet.
    task automatic config_regs(logic [mvm_pkg::COUNT_W-1:0] rows_val,
                               logic [mvm_pkg::COUNT_W-1:0] cols_val);
        int settle;
        settle = clamp_count(row_setting) * clamp_count(col_setting) + 2;
        wait_drained();
        repeat (settle) @(posedge clk);
        apb_write(mvm_pkg::REG_ROWS, rows_val);
        apb_write(mvm_pkg::REG_COLS, cols_val);
        apb_check(mvm_pkg::REG_ROWS);
        apb_check(mvm_pkg::REG_COLS);
        configs_applied++;
    endtask

    // Writes every weight and element that the product needs and that was not yet
    // written (plus some rewrites and stray writes) in shuffled order, then completes the vector.
    task automatic run_product();
        mv_item_t batch[$];
        mv_item_t tmp;
        int       rows_use;
        int       cols_use;
        int       k;
        rows_use = clamp_count(row_setting);
        cols_use = clamp_count(col_setting);
        for (int r = 0; r < rows_use; r++)
            for (int c = 0; c < cols_use; c++)
                if (!weight_written[r][c] || $urandom_range(0, 5) == 0)
                    batch.push_back(make_item(mvm_pkg::OP_WEIGHT, r, c, pick_value()));
        for (int c = 0; c < cols_use - 1; c++)
            if (!vector_written[c] || $urandom_range(0, 2) != 0)
                batch.push_back(make_item(mvm_pkg::OP_VECTOR, $urandom_range(0, 15), c,
                                          pick_value()));
        repeat ($urandom_range(0, 3))
            batch.push_back(make_noise(cols_use));
        for (int i = batch.size() - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            tmp = batch[i];
            batch[i] = batch[k];
            batch[k] = tmp;
        end
        foreach (batch[i])
            send_item(batch[i]);
        send_item(make_item(mvm_pkg::OP_VECTOR, $urandom_range(0, 15), cols_use - 1,
                            pick_value()));
    endtask

    // One-by-one products over the value extremes.
    task automatic test_single_element();
        config_regs(5'd1, 5'd1);
        send_item(make_item(mvm_pkg::OP_WEIGHT, 0, 0, 16'sh7FFF));
        send_item(make_item(mvm_pkg::OP_VECTOR, 0, 0, 16'sh8000));
        send_item(make_item(mvm_pkg::OP_WEIGHT, 0, 0, 16'sh8000));
        send_item(make_item(mvm_pkg::OP_VECTOR, 0, 0, 16'sh8000));
        send_item(make_item(mvm_pkg::OP_WEIGHT, 0, 0, 16'sh7FFF));
        send_item(make_item(mvm_pkg::OP_VECTOR, 15, 0, 16'sh7FFF));
        send_item(make_item(mvm_pkg::OP_WEIGHT, 0, 0, '0));
        send_item(make_item(mvm_pkg::OP_VECTOR, 0, 0, 16'sh5A5A));
    endtask

    // Writes at the top indexes, beyond the counts in use, and zero counts.
    task automatic test_index_limits();
        send_item(make_item(mvm_pkg::OP_WEIGHT, 15, 15, 16'sh8000));
        send_item(make_item(mvm_pkg::OP_WEIGHT, 15, 0, 16'sh1234));
        // Stored, but outside the vector in use, so no product starts.
        send_item(make_item(mvm_pkg::OP_VECTOR, 0, 15, 16'sh7FFF));
        send_item(make_item(mvm_pkg::OP_WEIGHT, 0, 0, 16'shFFFF));
        send_item(make_item(mvm_pkg::OP_VECTOR, 7, 0, 16'shFFFF));
        config_regs(5'd0, 5'd0);
        send_item(make_item(mvm_pkg::OP_VECTOR, 0, 0, 16'sh0100));
    endtask

    task automatic test_random();
        logic [mvm_pkg::COUNT_W-1:0] rows_val;
        logic [mvm_pkg::COUNT_W-1:0] cols_val;
        bit                          drained_once;
        drained_once = 1'b0;
        while (items_sent < RANDOM_TARGET) begin
            rows_val = pick_count();
            cols_val = pick_count();
            // Keep the weight traffic down when one side is at full size.
            if (clamp_count(rows_val) > 4)
                cols_val = mvm_pkg::COUNT_W'($urandom_range(1, 3));
            else if (clamp_count(cols_val) > 4)
                rows_val = mvm_pkg::COUNT_W'($urandom_range(1, 3));
            idle_on = ($urandom_range(0, 9) < 7);
            config_regs(rows_val, cols_val);
            repeat ($urandom_range(1, 3)) begin
                run_product();
                if (!drained_once || $urandom_range(0, 4) == 0) begin
                    wait_drained();
                    drained_once = 1'b1;
                end
            end
            // Now and then a half-written vector is left behind.
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4))
                    send_item(make_noise(clamp_count(col_setting)));
        end
    endtask

    task automatic test_full_size();
        idle_on = 1'b1;
        config_regs(5'd16, 5'd16);
        run_product();
        run_product();
    endtask

    // Closing stretch with the input side never idle.
    task automatic test_back_to_back();
        idle_on = 1'b0;
        do begin
            config_regs(mvm_pkg::COUNT_W'($urandom_range(1, 4)),
                        mvm_pkg::COUNT_W'($urandom_range(1, 4)));
            run_product();
            run_product();
        end while (items_sent < TOTAL_TARGET);
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_element();
        test_index_limits();
        test_random();
        test_full_size();
        test_back_to_back();
        wait_drained();
        repeat (clamp_count(row_setting) * clamp_count(col_setting) + 8) @(posedge clk);
        $display("Covered %0d input transfers (%0d weight writes), %0d products, %0d rows checked.",
                 items_sent, weight_items, products, dots_checked);
        $display("Counts were set %0d times, including zero, full-size and over-range values.",
                 configs_applied);
        if (error_count == 0)
            $display("matrix_vector_multiply_top verification clean");
        else
            $display("matrix_vector_multiply_top verification failed");
        $finish;
    end

    // Each result transfer is matched against the oldest queued dot product.
    always @(posedge clk) begin
        dot_result_t want;
        if (rst_n && done === 1'b1) begin
            if (expected_dots.size() == 0) begin
                error_count++;
                $display("%0t: result for row %0d arrived with nothing expected", $time, out_row);
            end
            else begin
                want = expected_dots.pop_front();
                dots_checked++;
                if (out_row !== want.row) begin
                    error_count++;
                    $display("%0t: out_row expected %0d, got %0d", $time, want.row, out_row);
                end
                if (product_sum !== want.sum) begin
                    error_count++;
                    $display("%0t: row %0d product_sum expected %0d, got %0d",
                             $time, want.row, want.sum, product_sum);
                end
                if (last !== want.last) begin
                    error_count++;
                    $display("%0t: row %0d last expected %0b, got %0b",
                             $time, want.row, want.last, last);
                end
            end
        end
    end

    // The run is abandoned when no transfer of any kind has happened for too long.
    always @(posedge clk) begin
        if (!rst_n || (start && busy === 1'b0) || done === 1'b1
                || (psel && penable && pready === 1'b1))
            stall_cycles = 0;
        else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
                $display("matrix_vector_multiply_top verification failed");
                $finish;
            end
        end
    end

endmodule
